// ===== rtl/ptts_pkg.sv =====
// Shared types and codes for the periodic task table scheduler.
package ptts_pkg;

   localparam int ID_W      = 8;
   localparam int TIME_W    = 32;
   localparam int MODE_W    = 3;
   localparam int TCOUNT_W  = 4;

   // A run scan reports at most this many tasks.
   localparam int MAX_RESULTS = 8;
   localparam int RESULT_W    = $clog2(MAX_RESULTS);

   localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_RUN    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ADD    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ENABLE = 3'd4;

   localparam int ACT_W = 3;
   localparam logic [ACT_W-1:0] ACT_NOP    = 3'd0;
   localparam logic [ACT_W-1:0] ACT_ADD    = 3'd1;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd2;
   localparam logic [ACT_W-1:0] ACT_ENABLE = 3'd3;
   localparam logic [ACT_W-1:0] ACT_SNAP   = 3'd4;
   localparam logic [ACT_W-1:0] ACT_FIRE   = 3'd5;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] next_run;
      logic              enabled;
   } entry_type;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] offset;
      logic              enable;
      logic [TIME_W-1:0] ticks;
   } ctl_type;

   typedef struct packed {
      logic              selected;
      logic              rest;
      logic [ID_W-1:0]   fire_id;
   } stat_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [ID_W-1:0]   task_id;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] offset;
      logic              enable;
   } req_type;

endpackage

// ===== rtl/periodic_task_table_scheduler.sv =====
// Top level: command sequencer, tick counter and result register over a row of task slots.
// Each transaction is accepted while idle, then executed; its result is registered.
// Tick, add, remove and set-enable give a single result. A run scan takes a snapshot and
// then gives one result per due task (at most eight), or one empty result if none is due.
// A new result waits while rsp_ready is low and the previous one is still held.
// Reset clears the table, the task count and the tick count.
module periodic_task_table_scheduler #(
   parameter int TASK_SLOTS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ptts_pkg::MODE_W-1:0]     req_mode,
   input  logic [ptts_pkg::ID_W-1:0]       req_task_id,
   input  logic [ptts_pkg::TIME_W-1:0]     req_period,
   input  logic [ptts_pkg::TIME_W-1:0]     req_offset,
   input  logic                            req_enable,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_ok,
   output logic                            rsp_fired,
   output logic [ptts_pkg::ID_W-1:0]       rsp_fired_task,
   output logic [ptts_pkg::TIME_W-1:0]     rsp_tick_count,
   output logic [ptts_pkg::TCOUNT_W-1:0]   rsp_task_count,
   output logic                            rsp_last
);

   localparam int CNT_W = $clog2(TASK_SLOTS + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(TASK_SLOTS);
   localparam logic [ptts_pkg::RESULT_W-1:0] LAST_N =
      ptts_pkg::RESULT_W'(ptts_pkg::MAX_RESULTS - 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   logic [1:0]                      state_ff, state_in;
   ptts_pkg::req_type               cmd_ff, cmd_in;
   logic [ptts_pkg::TIME_W-1:0]     ticks_ff, ticks_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [ptts_pkg::RESULT_W-1:0]   n_ff, n_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            ok_ff, ok_in;
   logic                            fired_ff, fired_in;
   logic [ptts_pkg::ID_W-1:0]       fired_task_ff, fired_task_in;
   logic [ptts_pkg::TIME_W-1:0]     tick_out_ff, tick_out_in;
   logic [ptts_pkg::TCOUNT_W-1:0]   task_count_ff, task_count_in;
   logic                            last_ff, last_in;

   ptts_pkg::ctl_type               ctl;
   logic [ptts_pkg::ACT_W-1:0]      action;
   ptts_pkg::entry_type             entry_out [TASK_SLOTS];
   ptts_pkg::stat_type              stat      [TASK_SLOTS];
   logic [TASK_SLOTS:0]             found_chain;
   logic [TASK_SLOTS:0]             pending_chain;
   logic [TASK_SLOTS-1:0]           sel_vec;
   logic [TASK_SLOTS-1:0]           rest_vec;
   logic [ptts_pkg::ID_W-1:0]       fire_id;
   logic                            found;
   logic                            any_pending;
   logic                            more;
   logic                            slot_free;
   logic                            is_last;

   assign found_chain[0]   = 1'b0;
   assign pending_chain[0] = 1'b0;

   assign ctl.action = action;
   assign ctl.id     = cmd_ff.task_id;
   assign ctl.period = cmd_ff.period;
   assign ctl.offset = cmd_ff.offset;
   assign ctl.enable = cmd_ff.enable;
   assign ctl.ticks  = ticks_ff;

   for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_slot
      ptts_pkg::entry_type above;
      if (i == TASK_SLOTS - 1) begin : g_top
         assign above = '0;
      end else begin : g_mid
         assign above = entry_out[i+1];
      end
      ptts_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .count       (count_ff),
         .above_in    (above),
         .found_in    (found_chain[i]),
         .pending_in  (pending_chain[i]),
         .entry_out   (entry_out[i]),
         .found_out   (found_chain[i+1]),
         .pending_out (pending_chain[i+1]),
         .stat        (stat[i])
      );
      assign sel_vec[i]  = stat[i].selected;
      assign rest_vec[i] = stat[i].rest;
   end

   always_comb begin
      fire_id = '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
         fire_id = fire_id | stat[i].fire_id;
      end
   end

   assign found       = found_chain[TASK_SLOTS];
   assign any_pending = pending_chain[TASK_SLOTS];
   assign more        = |rest_vec;
   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign is_last     = !more || (n_ff == LAST_N);
   assign req_ready   = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      ticks_in      = ticks_ff;
      count_in      = count_ff;
      n_in          = n_ff;
      action        = ptts_pkg::ACT_NOP;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      ok_in         = ok_ff;
      fired_in      = fired_ff;
      fired_task_in = fired_task_ff;
      tick_out_in   = tick_out_ff;
      task_count_in = task_count_ff;
      last_in       = last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in.mode    = req_mode;
               cmd_in.task_id = req_task_id;
               cmd_in.period  = req_period;
               cmd_in.offset  = req_offset;
               cmd_in.enable  = req_enable;
               state_in       = S_EXEC;
            end
         end
         S_EXEC: begin
            if (cmd_ff.mode == ptts_pkg::MODE_RUN) begin
               action   = ptts_pkg::ACT_SNAP;
               n_in     = '0;
               state_in = S_SCAN;
            end else if (slot_free) begin
               ok_in = 1'b0;
               case (cmd_ff.mode)
                  ptts_pkg::MODE_TICK: begin
                     ticks_in = ticks_ff + 32'd1;
                  end
                  ptts_pkg::MODE_ADD: begin
                     if ((count_ff < FULL) && (cmd_ff.task_id != '0) && !found) begin
                        ok_in    = 1'b1;
                        action   = ptts_pkg::ACT_ADD;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ptts_pkg::MODE_REMOVE: begin
                     if (found) begin
                        ok_in    = 1'b1;
                        action   = ptts_pkg::ACT_REMOVE;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  ptts_pkg::MODE_ENABLE: begin
                     if (found) begin
                        ok_in  = 1'b1;
                        action = ptts_pkg::ACT_ENABLE;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_valid_in  = 1'b1;
               fired_in      = 1'b0;
               fired_task_in = '0;
               tick_out_in   = ticks_in;
               task_count_in = ptts_pkg::TCOUNT_W'(count_in);
               last_in       = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_SCAN: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               ok_in         = 1'b0;
               tick_out_in   = ticks_ff;
               task_count_in = ptts_pkg::TCOUNT_W'(count_ff);
               if (!any_pending) begin
                  fired_in      = 1'b0;
                  fired_task_in = '0;
                  last_in       = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  action        = ptts_pkg::ACT_FIRE;
                  fired_in      = 1'b1;
                  fired_task_in = fire_id;
                  last_in       = is_last;
                  n_in          = n_ff + ptts_pkg::RESULT_W'(1);
                  if (is_last) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      n_ff          <= n_in;
      ok_ff         <= ok_in;
      fired_ff      <= fired_in;
      fired_task_ff <= fired_task_in;
      tick_out_ff   <= tick_out_in;
      task_count_ff <= task_count_in;
      last_ff       <= last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         ticks_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ticks_ff     <= ticks_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = ok_ff;
   assign rsp_fired      = fired_ff;
   assign rsp_fired_task = fired_task_ff;
   assign rsp_tick_count = tick_out_ff;
   assign rsp_task_count = task_count_ff;
   assign rsp_last       = last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL)
      else $error("task count exceeds the table size");

   a_one_selected: assert property (@(posedge clock) disable iff (reset)
      $onehot0(sel_vec))
      else $error("more than one slot selected during a run scan");

   a_fired_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && fired_ff) |-> (!ok_ff && (fired_task_ff != '0)))
      else $error("fired result carries ok or a zero task id");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_EXEC))
      else $error("accepted transaction did not enter execution");

endmodule

// ===== rtl/ptts_cell.sv =====
// One table slot: holds a task entry and passes search and shift data to its neighbors.
module ptts_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  ptts_pkg::ctl_type   ctl,
   input  logic [CNT_W-1:0]    count,
   input  ptts_pkg::entry_type above_in,
   input  logic                found_in,
   input  logic                pending_in,
   output ptts_pkg::entry_type entry_out,
   output logic                found_out,
   output logic                pending_out,
   output ptts_pkg::stat_type  stat
);

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

   ptts_pkg::entry_type entry_ff, entry_in;
   logic                pend_ff, pend_in;
   logic                match;
   logic                due;
   logic                sel;
   logic [ptts_pkg::TIME_W-1:0] resched;

   assign match   = (entry_ff.id == ctl.id) && (ctl.id != '0);
   assign due     = entry_ff.enabled && (ctl.ticks >= entry_ff.next_run);
   assign sel     = pend_ff && !pending_in;
   assign resched = ctl.ticks + entry_ff.period;

   // Found and pending travel upward: each is true if it holds here or in a lower slot.
   assign found_out   = found_in | match;
   assign pending_out = pending_in | pend_ff;
   assign entry_out   = entry_ff;

   assign stat.selected = sel;
   assign stat.rest     = pend_ff && pending_in;
   assign stat.fire_id  = sel ? entry_ff.id : '0;

   always_comb begin
      entry_in = entry_ff;
      pend_in  = pend_ff;
      case (ctl.action)
         ptts_pkg::ACT_ADD: begin
            if (count == MY_IDX) begin
               entry_in.id       = ctl.id;
               entry_in.period   = ctl.period;
               entry_in.next_run = ctl.offset;
               entry_in.enabled  = 1'b1;
            end
         end
         ptts_pkg::ACT_REMOVE: begin
            // Slots at and above the removed one take the contents of the slot above.
            if (found_out) begin
               entry_in = above_in;
            end
         end
         ptts_pkg::ACT_ENABLE: begin
            if (match) begin
               entry_in.enabled = ctl.enable;
               if (ctl.enable && (entry_ff.next_run <= ctl.ticks)) begin
                  entry_in.next_run = resched;
               end
            end
         end
         ptts_pkg::ACT_SNAP: begin
            pend_in = due;
         end
         ptts_pkg::ACT_FIRE: begin
            if (sel) begin
               pend_in           = 1'b0;
               entry_in.next_run = resched;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff.period   <= entry_in.period;
      entry_ff.next_run <= entry_in.next_run;
      if (reset) begin
         entry_ff.id      <= '0;
         entry_ff.enabled <= 1'b0;
         pend_ff          <= 1'b0;
      end else begin
         entry_ff.id      <= entry_in.id;
         entry_ff.enabled <= entry_in.enabled;
         pend_ff          <= pend_in;
      end
   end

endmodule
